/* hdl/cfd_local_timestep_assert.svh */
// Assertion macros used by the checker of the local time step block.
`ifndef CFD_LOCAL_TIMESTEP_ASSERT_SVH
`define CFD_LOCAL_TIMESTEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CLTP_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cltp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CLTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cltp assertion failed");

`endif

/* hdl/cltp_pkg.sv */
`timescale 1ns / 1ps
package cltp_pkg;

  // Fixed point format of every value
  localparam int FRAC_BITS = 16;

  localparam int GAMMA_W = 18;
  localparam int CFL_W   = 23;
  localparam int CFG_W   = 23;

  // Register indexes
  localparam logic CFG_IDX_GAMMA = 1'b0;
  localparam logic CFG_IDX_CFL   = 1'b1;

  localparam logic [GAMMA_W-1:0] GAMMA_RST = GAMMA_W'((64'd7 << FRAC_BITS) / 5);
  localparam logic [CFL_W-1:0]   CFL_RST   = CFL_W'(64'd1 << FRAC_BITS);

  // Status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // Iterative unit lengths
  localparam int DIV_W      = 54;
  localparam int DEN_W      = 40;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 6;

  // Face queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [DEN_W-1:0] SUM_MAX = {DEN_W{1'b1}};

  typedef struct packed {
    logic [GAMMA_W-1:0] gamma;
    logic [CFL_W-1:0]   cfl;
  } cfg_t;

  // One classified face: magnitudes plus the sign of each velocity product
  typedef struct packed {
    logic [30:0]       density;
    logic [30:0]       pressure;
    logic [30:0]       volume;
    logic              last_face;
    logic [2:0][31:0]  vel_mag;
    logic [2:0][31:0]  nrm_mag;
    logic [2:0]        dot_neg;
  } face_t;

endpackage

/* hdl/cfd_local_timestep.sv */
`timescale 1ns / 1ps
// Local time step from the convective spectral radius. Faces stream in grouped
// by cell; each adds (|V.n|/|n| + c)*|n| with c = sqrt(gamma*p/rho) to the cell
// sum, and the face flagged last yields the radius, dt = cfl*volume/radius and a
// status (0 ok, 1 saturated, 2 zero radius). Values are Q16.16. One sequencer
// does all the work with a shared 32x32 multiplier, a one-bit-per-cycle divider
// (54 steps) and a one-bit-per-cycle square root (32 steps, used twice). The
// divide for the ratio is skipped when density is zero, and a cell's last face
// adds the time step division (skipped when the radius is zero). A
// two-entry face queue in front lets faces be taken while the sequencer works;
// a result waits in the output register while the next faces proceed. gamma
// and cfl are written on the cfg port (index 0 gamma, 1 cfl); the user must
// write them only while the block is idle, which the block does not enforce.
module cfd_local_timestep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cltp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [30:0]                 density_i,
  input  logic [30:0]                 pressure_i,
  input  logic signed [31:0]          vel_x_i,
  input  logic signed [31:0]          vel_y_i,
  input  logic signed [31:0]          vel_z_i,
  input  logic signed [31:0]          normal_x_i,
  input  logic signed [31:0]          normal_y_i,
  input  logic signed [31:0]          normal_z_i,
  input  logic [30:0]                 cell_vol_i,
  input  logic                        last_face_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 radius_o,
  output logic [31:0]                 time_step_o,
  output logic [1:0]                  status_o
);

  cltp_pkg::cfg_t  cfg_q;
  cltp_pkg::face_t push_face, pop_face;
  logic            push, full, pop, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma <= cltp_pkg::GAMMA_RST;
      cfg_q.cfl   <= cltp_pkg::CFL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cltp_pkg::CFG_IDX_GAMMA: cfg_q.gamma <= cfg_wdata_i[cltp_pkg::GAMMA_W-1:0];
        cltp_pkg::CFG_IDX_CFL:   cfg_q.cfl   <= cfg_wdata_i[cltp_pkg::CFL_W-1:0];
        default: ;
      endcase
    end
  end

  cltp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .density_i, .pressure_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i, .cell_vol_i, .last_face_i,
    .push_o (push),
    .face_o (push_face),
    .full_i (full)
  );

  cltp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (push_face),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_face)
  );

  cltp_back u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .face_i  (pop_face),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .radius_o, .time_step_o, .status_o
  );

endmodule

/* hdl/cltp_front.sv */
`timescale 1ns / 1ps
module cltp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [30:0]          density_i,
  input  logic [30:0]          pressure_i,
  input  logic signed [31:0]   vel_x_i,
  input  logic signed [31:0]   vel_y_i,
  input  logic signed [31:0]   vel_z_i,
  input  logic signed [31:0]   normal_x_i,
  input  logic signed [31:0]   normal_y_i,
  input  logic signed [31:0]   normal_z_i,
  input  logic [30:0]          cell_vol_i,
  input  logic                 last_face_i,
  output logic                 push_o,
  output cltp_pkg::face_t      face_o,
  input  logic                 full_i
);

  logic            vld_q, vld_d;
  logic            accept;
  cltp_pkg::face_t face_q, face_d;
  logic [2:0][31:0] vel, nrm;

  assign vel = {vel_z_i, vel_y_i, vel_x_i};
  assign nrm = {normal_z_i, normal_y_i, normal_x_i};

  assign in_stall_o = vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = vld_q && !full_i;
  assign face_o     = face_q;
  assign vld_d      = accept || (vld_q && !push_o);

  // Split each signed component into magnitude and sign
  always_comb begin
    face_d.density     = density_i;
    face_d.pressure    = pressure_i;
    face_d.volume      = cell_vol_i;
    face_d.last_face   = last_face_i;
    for (int k = 0; k < 3; k++) begin
      face_d.vel_mag[k] = vel[k][31] ? (~vel[k] + 32'd1) : vel[k];
      face_d.nrm_mag[k] = nrm[k][31] ? (~nrm[k] + 32'd1) : nrm[k];
      face_d.dot_neg[k] = vel[k][31] ^ nrm[k][31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      face_q <= face_d;
    end
  end

endmodule

/* hdl/cltp_queue.sv */
`timescale 1ns / 1ps
module cltp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cltp_pkg::face_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cltp_pkg::face_t data_o
);

  cltp_pkg::face_t               mem_q [cltp_pkg::QUEUE_DEPTH];
  logic [cltp_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [cltp_pkg::QPTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (cltp_pkg::QPTR_W+1)'(cltp_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* hdl/cltp_back.sv */
`timescale 1ns / 1ps
module cltp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cltp_pkg::cfg_t       cfg_i,
  input  logic                 empty_i,
  input  cltp_pkg::face_t      face_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          radius_o,
  output logic [31:0]          time_step_o,
  output logic [1:0]           status_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_GP, S_MUL_NX, S_MUL_NY, S_MUL_NZ, S_MUL_VX, S_MUL_VY,
    S_MUL_VZ, S_DOT, S_ABS, S_Q_DIV, S_Q_SAT, S_C_SQRT, S_A_SQRT,
    S_MUL_CD, S_TERM, S_MUL_VOL, S_DT_INIT, S_DT_DIV, S_EMIT
  } state_e;

  localparam int DW = cltp_pkg::DIV_W;
  localparam int NW = cltp_pkg::DEN_W;

  state_e               state_q;
  cltp_pkg::face_t      ent_q;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod_q;
  logic [63:0]          area_q, pos_q, neg_q, dot_q;
  logic [23:0]          c_q;
  logic [31:0]          ds_q;
  logic [cltp_pkg::CNT_W-1:0] cnt_q;
  logic [NW-1:0]        sum_q;
  logic                 sat_q;

  // divider registers
  logic [DW-1:0]        num_q, num_nx;
  logic [NW:0]          rem_q, rem_sh, rem_nx;
  logic [NW-1:0]        den_q;
  logic                 div_ge;

  // square root registers
  logic [63:0]          sop_q;
  logic [34:0]          srem_q, srem_sh, strial, srem_nx;
  logic [31:0]          root_q, root_nx;
  logic                 sq_ge;

  // accumulation
  logic [63:0]          term_full;
  logic [47:0]          term_raw;
  logic [NW-1:0]        term;
  logic                 term_sat;
  logic [NW:0]          sum_add;
  logic [NW-1:0]        sum_nx;
  logic                 sum_sat;

  // result forming
  logic                 out_free;
  logic [31:0]          res_radius, res_dt;
  logic [1:0]           res_status;

  logic                 div_last, sq_last;

  // Shared 32x32 multiplier, operand select by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_GP:  begin mul_a = 32'(cfg_i.gamma); mul_b = 32'(ent_q.pressure); end
      S_MUL_NX:  begin mul_a = ent_q.nrm_mag[0]; mul_b = ent_q.nrm_mag[0]; end
      S_MUL_NY:  begin mul_a = ent_q.nrm_mag[1]; mul_b = ent_q.nrm_mag[1]; end
      S_MUL_NZ:  begin mul_a = ent_q.nrm_mag[2]; mul_b = ent_q.nrm_mag[2]; end
      S_MUL_VX:  begin mul_a = ent_q.vel_mag[0]; mul_b = ent_q.nrm_mag[0]; end
      S_MUL_VY:  begin mul_a = ent_q.vel_mag[1]; mul_b = ent_q.nrm_mag[1]; end
      S_MUL_VZ:  begin mul_a = ent_q.vel_mag[2]; mul_b = ent_q.nrm_mag[2]; end
      S_MUL_CD:  begin mul_a = 32'(c_q); mul_b = ds_q; end
      S_MUL_VOL: begin mul_a = 32'(cfg_i.cfl); mul_b = 32'(ent_q.volume); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Restoring divide step, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[NW-1:0], num_q[DW-1]};
    div_ge = rem_sh >= {1'b0, den_q};
    rem_nx = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    num_nx = {num_q[DW-2:0], div_ge};
  end

  // Square root step, one root bit per cycle
  always_comb begin
    srem_sh = {srem_q[32:0], sop_q[63:62]};
    strial  = {1'b0, root_q, 2'b01};
    sq_ge   = srem_sh >= strial;
    srem_nx = sq_ge ? (srem_sh - strial) : srem_sh;
    root_nx = {root_q[30:0], sq_ge};
  end

  assign div_last = cnt_q == cltp_pkg::CNT_W'(DW - 1);
  assign sq_last  = cnt_q == cltp_pkg::CNT_W'(cltp_pkg::SQRT_STEPS - 1);

  // Face term and saturating cell sum
  always_comb begin
    term_full = dot_q + prod_q;
    term_raw  = term_full[cltp_pkg::FRAC_BITS +: 48];
    term_sat  = term_raw[47:NW] != '0;
    term      = term_sat ? cltp_pkg::SUM_MAX : term_raw[NW-1:0];
    sum_add   = {1'b0, sum_q} + {1'b0, term};
    sum_sat   = sum_add[NW];
    sum_nx    = sum_sat ? cltp_pkg::SUM_MAX : sum_add[NW-1:0];
  end

  // Result fields from the finished cell
  always_comb begin
    res_status = sat_q ? cltp_pkg::STATUS_SAT : cltp_pkg::STATUS_OK;
    res_radius = sum_q[31:0];
    if (sum_q[NW-1:32] != '0) begin
      res_radius = '1;
      res_status = cltp_pkg::STATUS_SAT;
    end
    if (sum_q == '0) begin
      res_dt     = '1;
      res_status = cltp_pkg::STATUS_ZERO;
    end else if (num_q[DW-1:32] != '0) begin
      res_dt     = '1;
      res_status = cltp_pkg::STATUS_SAT;
    end else begin
      res_dt     = num_q[31:0];
    end
  end

  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Sequencer: state, working values and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_o <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // taken result drops valid unless a new one is loaded this cycle
      if (out_valid_o && !out_stall_i && state_q != S_EMIT) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            ent_q   <= face_i;
            state_q <= S_MUL_GP;
          end
        end
        S_MUL_GP: state_q <= S_MUL_NX;
        S_MUL_NX: begin
          num_q   <= prod_q[DW-1:0];
          state_q <= S_MUL_NY;
        end
        S_MUL_NY: begin
          area_q  <= prod_q;
          state_q <= S_MUL_NZ;
        end
        S_MUL_NZ: begin
          area_q  <= area_q + prod_q;
          state_q <= S_MUL_VX;
        end
        S_MUL_VX: begin
          area_q  <= area_q + prod_q;
          state_q <= S_MUL_VY;
        end
        S_MUL_VY: begin
          pos_q   <= ent_q.dot_neg[0] ? '0 : prod_q;
          neg_q   <= ent_q.dot_neg[0] ? prod_q : '0;
          state_q <= S_MUL_VZ;
        end
        S_MUL_VZ: begin
          if (ent_q.dot_neg[1]) neg_q <= neg_q + prod_q;
          else                  pos_q <= pos_q + prod_q;
          state_q <= S_DOT;
        end
        S_DOT: begin
          if (ent_q.dot_neg[2]) neg_q <= neg_q + prod_q;
          else                  pos_q <= pos_q + prod_q;
          state_q <= S_ABS;
        end
        S_ABS: begin
          dot_q <= (pos_q >= neg_q) ? (pos_q - neg_q) : (neg_q - pos_q);
          cnt_q <= '0;
          if (ent_q.density == '0) begin
            // no density: ratio pinned at its maximum
            sat_q   <= 1'b1;
            sop_q   <= 64'(32'hFFFF_FFFF) << cltp_pkg::FRAC_BITS;
            srem_q  <= '0;
            root_q  <= '0;
            state_q <= S_C_SQRT;
          end else begin
            den_q   <= NW'(ent_q.density);
            rem_q   <= '0;
            state_q <= S_Q_DIV;
          end
        end
        S_Q_DIV: begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q + 1'b1;
          if (div_last) state_q <= S_Q_SAT;
        end
        S_Q_SAT: begin
          if (num_q[DW-1:32] != '0) begin
            sat_q <= 1'b1;
            sop_q <= 64'(32'hFFFF_FFFF) << cltp_pkg::FRAC_BITS;
          end else begin
            sop_q <= 64'(num_q[31:0]) << cltp_pkg::FRAC_BITS;
          end
          srem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= '0;
          state_q <= S_C_SQRT;
        end
        S_C_SQRT: begin
          sop_q  <= sop_q << 2;
          srem_q <= srem_nx;
          root_q <= root_nx;
          cnt_q  <= cnt_q + 1'b1;
          if (sq_last) begin
            c_q     <= root_nx[23:0];
            sop_q   <= area_q;
            srem_q  <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_A_SQRT;
          end
        end
        S_A_SQRT: begin
          sop_q  <= sop_q << 2;
          srem_q <= srem_nx;
          root_q <= root_nx;
          cnt_q  <= cnt_q + 1'b1;
          if (sq_last) begin
            ds_q    <= root_nx;
            state_q <= S_MUL_CD;
          end
        end
        S_MUL_CD: state_q <= S_TERM;
        S_TERM: begin
          sum_q <= sum_nx;
          if (term_sat || sum_sat) sat_q <= 1'b1;
          state_q <= ent_q.last_face ? S_MUL_VOL : S_IDLE;
        end
        S_MUL_VOL: state_q <= S_DT_INIT;
        S_DT_INIT: begin
          num_q <= prod_q[DW-1:0];
          den_q <= sum_q;
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= (sum_q == '0) ? S_EMIT : S_DT_DIV;
        end
        S_DT_DIV: begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q + 1'b1;
          if (div_last) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            radius_o          <= res_radius;
            time_step_o       <= res_dt;
            status_o          <= res_status;
            out_valid_o       <= 1'b1;
            sum_q             <= '0;
            sat_q             <= 1'b0;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/cltp_checker.sv */
`timescale 1ns / 1ps
`include "cfd_local_timestep_assert.svh"
module cltp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] radius_o,
  input logic [31:0] time_step_o,
  input logic [1:0]  status_o
);

  // a stalled result holds
  `CLTP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(time_step_o) && $stable(radius_o) && $stable(status_o))

  // zero radius pairs with a maximal time step
  `CLTP_ASSERT_NOW(a_zero_radius, clk_i, rst_ni, out_valid_o && status_o == cltp_pkg::STATUS_ZERO, radius_o == 32'd0 && time_step_o == 32'hFFFF_FFFF)

  // a nonzero radius never reports the zero status
  `CLTP_ASSERT_NOW(a_nonzero_radius, clk_i, rst_ni, out_valid_o && radius_o != 32'd0, status_o != cltp_pkg::STATUS_ZERO)

endmodule

bind cfd_local_timestep cltp_checker u_cltp_checker (.*);
